// File: hdl/u8v_pkg.sv
package u8v_pkg;

    localparam logic [7:0]  ASCII_MAX      = 8'h7f;
    localparam logic [7:0]  LEAD2_MIN      = 8'hc2;
    localparam logic [7:0]  LEAD2_MAX      = 8'hdf;
    localparam logic [7:0]  LEAD3_MIN      = 8'he0;
    localparam logic [7:0]  LEAD3_MAX      = 8'hef;
    localparam logic [7:0]  LEAD4_MIN      = 8'hf0;
    localparam logic [7:0]  LEAD4_MAX      = 8'hf4;
    localparam logic [7:0]  CONT_MASK      = 8'hc0;
    localparam logic [7:0]  CONT_TAG       = 8'h80;
    localparam logic [20:0] CODE_MAX       = 21'h10ffff;
    localparam logic [20:0] SURR_MIN       = 21'h00d800;
    localparam logic [20:0] SURR_MAX       = 21'h00dfff;
    localparam logic [20:0] MIN_CODE2      = 21'h000080;
    localparam logic [20:0] MIN_CODE3      = 21'h000800;
    localparam logic [20:0] MIN_CODE4      = 21'h010000;

    localparam logic [2:0]  WIDTH1         = 3'd1;
    localparam logic [2:0]  WIDTH2         = 3'd2;
    localparam logic [2:0]  WIDTH3         = 3'd3;
    localparam logic [2:0]  WIDTH4         = 3'd4;

    function automatic logic code_ok(input logic [20:0] cp, input logic [2:0] width);
        logic ok;
        begin
            ok = 1'b1;
            if (width == WIDTH2 && cp < MIN_CODE2)
            begin
                ok = 1'b0;
            end
            if (width == WIDTH3 && cp < MIN_CODE3)
            begin
                ok = 1'b0;
            end
            if (width == WIDTH4 && cp < MIN_CODE4)
            begin
                ok = 1'b0;
            end
            if (cp > CODE_MAX)
            begin
                ok = 1'b0;
            end
            if (cp >= SURR_MIN && cp <= SURR_MAX)
            begin
                ok = 1'b0;
            end
            if (cp == 21'd0)
            begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

endpackage

// File: hdl/utf8_validator_no_nul.sv
// Strict UTF-8 checker that also rejects the NUL character.
// The input channel (in_valid, in_ready, byte_value, last_byte) carries one byte of
// the string per transaction; last_byte marks the final byte of a string.
// The output channel (out_valid, out_ready, text_valid) carries one verdict per
// string, produced only for the byte marked last.
// An accepted byte is held in an input register and then folded into the sequence
// state; the verdict for a string is registered in the output register (out_valid)
// when its last byte leaves the input register.
// Throughput is one byte per clock cycle, unless a last byte waits for the output.
// While a verdict waits on the output, bytes that are not last keep flowing; only a
// last byte waits in the input register until the output register is free, and
// in_ready then drops.
// Reset clears the sequence state, the error flag and both valid flags, so the first
// byte after reset begins a new string. After each verdict the state is cleared
// again in the same cycle.
module utf8_validator_no_nul
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       text_valid
);

    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_last_reg;

    logic        sticky_error_reg;
    logic        sticky_error_next;
    logic [1:0]  bytes_left_reg;
    logic [1:0]  bytes_left_next;
    logic [2:0]  seq_width_reg;
    logic [2:0]  seq_width_next;
    logic [20:0] code_accum_reg;
    logic [20:0] code_accum_next;

    logic        out_valid_reg;
    logic        text_valid_reg;

    logic        out_free;
    logic        stage_go;
    logic        verdict;

    assign out_free = !out_valid_reg || out_ready;
    assign stage_go = stg_valid_reg && (!stg_last_reg || out_free);
    assign in_ready = !stg_valid_reg || stage_go;
    assign out_valid = out_valid_reg;
    assign text_valid = text_valid_reg;

    always_comb
    begin
        sticky_error_next = sticky_error_reg;
        bytes_left_next = bytes_left_reg;
        seq_width_next = seq_width_reg;
        code_accum_next = code_accum_reg;
        if (!sticky_error_reg)
        begin
            if (bytes_left_reg == 2'd0)
            begin
                if (stg_byte_reg <= u8v_pkg::ASCII_MAX)
                begin
                    seq_width_next = u8v_pkg::WIDTH1;
                    code_accum_next = {13'd0, stg_byte_reg};
                    if (!u8v_pkg::code_ok({13'd0, stg_byte_reg}, u8v_pkg::WIDTH1))
                    begin
                        sticky_error_next = 1'b1;
                    end
                end
                else if (stg_byte_reg >= u8v_pkg::LEAD2_MIN
                         && stg_byte_reg <= u8v_pkg::LEAD2_MAX)
                begin
                    seq_width_next = u8v_pkg::WIDTH2;
                    bytes_left_next = 2'd1;
                    code_accum_next = {16'd0, stg_byte_reg[4:0]};
                end
                else if (stg_byte_reg >= u8v_pkg::LEAD3_MIN
                         && stg_byte_reg <= u8v_pkg::LEAD3_MAX)
                begin
                    seq_width_next = u8v_pkg::WIDTH3;
                    bytes_left_next = 2'd2;
                    code_accum_next = {17'd0, stg_byte_reg[3:0]};
                end
                else if (stg_byte_reg >= u8v_pkg::LEAD4_MIN
                         && stg_byte_reg <= u8v_pkg::LEAD4_MAX)
                begin
                    seq_width_next = u8v_pkg::WIDTH4;
                    bytes_left_next = 2'd3;
                    code_accum_next = {18'd0, stg_byte_reg[2:0]};
                end
                else
                begin
                    sticky_error_next = 1'b1;
                end
            end
            else if ((stg_byte_reg & u8v_pkg::CONT_MASK) != u8v_pkg::CONT_TAG)
            begin
                sticky_error_next = 1'b1;
            end
            else
            begin
                code_accum_next = {code_accum_reg[14:0], stg_byte_reg[5:0]};
                bytes_left_next = bytes_left_reg - 2'd1;
                if (bytes_left_next == 2'd0
                    && !u8v_pkg::code_ok(code_accum_next, seq_width_reg))
                begin
                    sticky_error_next = 1'b1;
                end
            end
        end
    end

    assign verdict = !sticky_error_next && (bytes_left_next == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_byte_reg <= byte_value;
            stg_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_error_reg <= 1'b0;
            bytes_left_reg <= 2'd0;
            seq_width_reg <= 3'd0;
            code_accum_reg <= 21'd0;
        end
        else if (stage_go)
        begin
            if (stg_last_reg)
            begin
                sticky_error_reg <= 1'b0;
                bytes_left_reg <= 2'd0;
                seq_width_reg <= 3'd0;
                code_accum_reg <= 21'd0;
            end
            else
            begin
                sticky_error_reg <= sticky_error_next;
                bytes_left_reg <= bytes_left_next;
                seq_width_reg <= seq_width_next;
                code_accum_reg <= code_accum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && stg_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && stg_last_reg)
        begin
            text_valid_reg <= verdict;
        end
    end

`ifndef ASSERT_OFF
    a_verdict_registered: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && stg_last_reg |=> out_valid_reg)
        else $error("Verdict of a last byte did not reach the output register.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(stage_go && stg_last_reg))
        else $error("A pending verdict was overwritten.");

    a_width_covers_left: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg != 2'd0 |-> seq_width_reg > {1'b0, bytes_left_reg})
        else $error("Sequence width does not cover the continuation bytes due.");

    a_cleared_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && stg_last_reg |=> bytes_left_reg == 2'd0 && !sticky_error_reg)
        else $error("State was not cleared after a verdict.");
`endif

endmodule

// File: test/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       text_valid;

    logic        err_seen = 1'b0;
    logic [1:0]  cont_due = 2'd0;
    logic [2:0]  char_len = 3'd0;
    logic [20:0] code_acc = 21'd0;

    logic        expected_verdicts[$];
    logic [7:0]  text_bytes[$];
    logic        want_valid;
    int          verdict_errors = 0;
    int          cycle_count = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    utf8_validator_no_nul i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .text_valid (text_valid)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL utf8_validator_no_nul");
            $finish;
        end
    end

    function automatic logic legal_code(input logic [20:0] cp, input logic [2:0] len);
        logic bad;
        begin
            bad = (len == u8v_pkg::WIDTH2 && cp < u8v_pkg::MIN_CODE2)
                || (len == u8v_pkg::WIDTH3 && cp < u8v_pkg::MIN_CODE3)
                || (len == u8v_pkg::WIDTH4 && cp < u8v_pkg::MIN_CODE4)
                || (cp > u8v_pkg::CODE_MAX)
                || (cp >= u8v_pkg::SURR_MIN && cp <= u8v_pkg::SURR_MAX) || (cp == 21'd0);
            return !bad;
        end
    endfunction

    function automatic void judge_byte(input logic [7:0] b, input logic last);
        if (!err_seen)
        begin
            if (cont_due == 2'd0)
            begin
                if (b <= u8v_pkg::ASCII_MAX)
                begin
                    char_len = u8v_pkg::WIDTH1;
                    code_acc = {13'd0, b};
                    if (!legal_code(code_acc, u8v_pkg::WIDTH1))
                    begin
                        err_seen = 1'b1;
                    end
                end
                else if (b >= u8v_pkg::LEAD2_MIN && b <= u8v_pkg::LEAD2_MAX)
                begin
                    char_len = u8v_pkg::WIDTH2;
                    cont_due = 2'd1;
                    code_acc = {16'd0, b[4:0]};
                end
                else if (b >= u8v_pkg::LEAD3_MIN && b <= u8v_pkg::LEAD3_MAX)
                begin
                    char_len = u8v_pkg::WIDTH3;
                    cont_due = 2'd2;
                    code_acc = {17'd0, b[3:0]};
                end
                else if (b >= u8v_pkg::LEAD4_MIN && b <= u8v_pkg::LEAD4_MAX)
                begin
                    char_len = u8v_pkg::WIDTH4;
                    cont_due = 2'd3;
                    code_acc = {18'd0, b[2:0]};
                end
                else
                begin
                    err_seen = 1'b1;
                end
            end
            else if ((b & u8v_pkg::CONT_MASK) != u8v_pkg::CONT_TAG)
            begin
                err_seen = 1'b1;
            end
            else
            begin
                code_acc = {code_acc[14:0], b[5:0]};
                cont_due = cont_due - 2'd1;
                if (cont_due == 2'd0 && !legal_code(code_acc, char_len))
                begin
                    err_seen = 1'b1;
                end
            end
        end
        if (last)
        begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     !err_seen && cont_due == 2'd0);
            err_seen = 1'b0;
            cont_due = 2'd0;
            char_len = 3'd0;
            code_acc = 21'd0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    verdict_errors++;
                    if (verdict_errors <= 10)
                    begin
                        $display("verdict with none expected: got text_valid=%0b", text_valid);
                    end
                end
                else
                begin
                    want_valid = expected_verdicts.pop_front();
                    if (text_valid !== want_valid)
                    begin
                        verdict_errors++;
                        if (verdict_errors <= 10)
                        begin
                            $display("verdict mismatch: expected text_valid=%0b, got %0b",
                                     want_valid, text_valid);
                        end
                    end
                end
            end
            out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        byte_value <= b;
        last_byte <= last;
        // The transaction completes at the first edge where in_ready is high.
        do
            @(posedge clk);
        while (!in_ready);
        judge_byte(b, last);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        text_bytes.delete();
    endtask

    function automatic void append_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic void put_char(input logic [20:0] cp, input int len);
        case (len)
            1:
            begin
                append_byte({1'b0, cp[6:0]});
            end
            2:
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] pick_code(input int len);
        logic [20:0] cp;
        begin
            case (len)
                1: cp = 21'($urandom_range(32'h7f, 1));
                2: cp = 21'($urandom_range(32'h7ff, 32'h80));
                3:
                begin
                    cp = 21'($urandom_range(32'hffff, 32'h800));
                    if (cp >= u8v_pkg::SURR_MIN && cp <= u8v_pkg::SURR_MAX)
                    begin
                        cp = cp ^ 21'h8000;
                    end
                end
                default: cp = 21'($urandom_range(32'h10ffff, 32'h10000));
            endcase
            return cp;
        end
    endfunction

    function automatic void put_bad_char();
        int len;
        begin
            case ($urandom_range(3))
                0: put_char(21'd0, 1);
                1:
                begin
                    len = $urandom_range(4, 2);
                    if (len == 2)
                        put_char(21'($urandom_range(32'h7f)), 2);
                    else if (len == 3)
                        put_char(21'($urandom_range(32'h7ff)), 3);
                    else
                        put_char(21'($urandom_range(32'hffff)), 4);
                end
                2: put_char(21'($urandom_range(32'hdfff, 32'hd800)), 3);
                default: put_char(21'($urandom_range(32'h1fffff, 32'h110000)), 4);
            endcase
        end
    endfunction

    function automatic void build_random_text();
        int shape;
        int chars;
        int bad_at;
        int len;
        begin
            shape = $urandom_range(99);
            chars = $urandom_range(6, 1);
            bad_at = -1;
            text_bytes.delete();
            if (shape < 10)
            begin
                repeat (chars) append_byte(8'($urandom_range(255)));
            end
            else
            begin
                if (shape >= 70 && shape < 80)
                begin
                    bad_at = $urandom_range(chars - 1);
                end
                for (int i = 0; i < chars; i++)
                begin
                    if (i == bad_at)
                    begin
                        put_bad_char();
                    end
                    else
                    begin
                        len = $urandom_range(4, 1);
                        put_char(pick_code(len), len);
                    end
                end
                if (shape >= 80 && shape < 90 && text_bytes.size() > 1)
                begin
                    void'(text_bytes.pop_back());
                end
                else if (shape >= 90)
                begin
                    text_bytes[$urandom_range(text_bytes.size() - 1)] = 8'($urandom_range(255));
                end
            end
        end
    endfunction

    task automatic send_random_text(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_random_text();
            sent += text_bytes.size();
            send_text();
        end
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_strings();
        gap_pct = 0;
        stall_pct = 0;
        text_bytes = {8'h00};
        send_text();
        text_bytes = {8'h7f};
        send_text();
        text_bytes = {8'hc2, 8'h80};
        send_text();
        text_bytes = {8'hc0, 8'hff, 8'h41};
        send_text();
        text_bytes = {8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_text();
        text_bytes = {8'he0, 8'h9f, 8'hbf};
        send_text();
        text_bytes = {8'hed, 8'ha0, 8'h80};
        send_text();
        text_bytes = {8'hf4, 8'h90};
        send_text();
        text_bytes = {8'hc2, 8'h41};
        send_text();
        text_bytes = {8'h80};
        send_text();
        text_bytes = {8'hf5};
        send_text();
    endtask

    task automatic test_streaming();
        gap_pct = 0;
        stall_pct = 0;
        send_random_text(330);
    endtask

    task automatic test_sparse_input();
        gap_pct = 58;
        stall_pct = 0;
        send_random_text(160);
        pause_until_drained();
        send_random_text(160);
    endtask

    task automatic test_stalled_output();
        gap_pct = 0;
        stall_pct = 58;
        send_random_text(330);
    endtask

    task automatic test_mixed_idle();
        gap_pct = 16;
        stall_pct = 16;
        send_random_text(330);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_strings();
        test_streaming();
        test_sparse_input();
        test_stalled_output();
        test_mixed_idle();
        pause_until_drained();
        repeat (10) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $display("%0d verdicts never arrived", expected_verdicts.size());
            verdict_errors += expected_verdicts.size();
        end
        if (verdict_errors == 0)
        begin
            $display("PASS utf8_validator_no_nul");
        end
        else
        begin
            $display("FAIL utf8_validator_no_nul");
        end
        $finish;
    end

endmodule
